// ===== rtl/spq_pkg.sv =====
// Package: types and constants shared by the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int TOKEN_W  = 31;
  localparam int OCC_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [TOKEN_W-1:0] token;
  } cmd_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] removed_token;
    status_t            status;
    logic [OCC_W-1:0]   occupancy;
  } result_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic               ins_en;
    logic               rem_en;
    logic [TOKEN_W-1:0] token;
  } cell_ctrl_t;

endpackage

// ===== rtl/sorted_priority_queue_top.sv =====
// Top level: sorted priority queue built as a chain of compare-and-shift cells.
//
// Usage:
//   Command channel: drive cmd and raise start; the word is taken at a rising
//   edge with start high and busy low. busy is always low: every command
//   finishes in the cycle it is taken, so a new word may follow every cycle.
//   cmd.op = OP_INSERT stores cmd.token; OP_REMOVE pops the largest token.
//   Among equal tokens the most recently inserted leaves first.
//   Result channel: exactly one result word per command, on result for one
//   cycle with done high, in the cycle after the command is taken
//   (throughput 1 word/cycle). Every cell compares against the broadcast
//   token in parallel and shifts by one slot, so the rate is set by one
//   31-bit compare plus a 4:1 select (keep, new, upper, lower) per cell.
//   The receiver cannot stall: a result not captured in its done cycle is gone.
//   Status: ST_EMPTY on remove from an empty queue (token 0, count kept),
//   ST_FULL on insert into a full queue (queue kept), else ST_OK.
//   occupancy is the stored count after the command.
//   Reset (rst, synchronous): count goes to zero, done drops. Cell contents
//   are not cleared; only slots below the count are ever read.
module sorted_priority_queue_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  spq_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output spq_pkg::result_t result
);
  import spq_pkg::*;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               done_next;
  result_t            result_next;
  cell_ctrl_t         ctrl;
  logic               accept;
  logic               is_full;
  logic               is_empty;

  logic [TOKEN_W-1:0] cell_data [CAPACITY];
  logic               cell_gt   [CAPACITY];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  // Broadcast control for the chain.
  assign ctrl.ins_en = accept && (cmd.op == OP_INSERT) && !is_full;
  assign ctrl.rem_en = accept && (cmd.op == OP_REMOVE) && !is_empty;
  assign ctrl.token  = cmd.token;

  // Chain: head is cell 0. On insert a cell either keeps its token, takes the
  // new one (first slot whose token is not greater), or takes its upper
  // neighbor's. On remove every cell but the tail takes its lower neighbor's token.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               p_gt;
    logic [TOKEN_W-1:0] p_data;
    logic [TOKEN_W-1:0] n_data;

    if (i == 0) begin : g_head
      assign p_gt   = 1'b1;
      assign p_data = cmd.token;
    end else begin : g_mid
      assign p_gt   = cell_gt[i-1];
      assign p_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_data = cell_data[i];
    end else begin : g_body
      assign n_data = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .slot_valid (CNT_W'(i) < count),
      .prev_gt    (p_gt),
      .prev_data  (p_data),
      .next_data  (n_data),
      .gt         (cell_gt[i]),
      .data       (cell_data[i])
    );
  end

  // Count and result word.
  always_comb begin
    count_next                = count;
    done_next                 = accept;
    result_next.removed_token = '0;
    result_next.status        = ST_OK;
    if (accept) begin
      if (cmd.op == OP_INSERT) begin
        if (is_full) begin
          result_next.status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end else begin
        if (is_empty) begin
          result_next.status = ST_EMPTY;
        end else begin
          result_next.removed_token = cell_data[0];
          count_next                = count - CNT_W'(1);
        end
      end
    end
    result_next.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Every accepted command produces a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted command gave no result");

  // Count never passes capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  // A refused command leaves the count alone.
  a_refused_keep: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_FULL || result.status == ST_EMPTY)
      |-> count == $past(count))
    else $error("refused command changed count");

  // Refused commands return a zero token.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.removed_token == '0)
    else $error("refused command returned a token");

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds a token, shifts toward tail or head.
module spq_cell (
  input  logic                       clk,
  input  spq_pkg::cell_ctrl_t        ctrl,
  input  logic                       slot_valid,
  input  logic                       prev_gt,
  input  logic [spq_pkg::TOKEN_W-1:0] prev_data,
  input  logic [spq_pkg::TOKEN_W-1:0] next_data,
  output logic                       gt,
  output logic [spq_pkg::TOKEN_W-1:0] data
);
  import spq_pkg::*;

  logic [TOKEN_W-1:0] data_next;

  // Stored token beats the incoming one; true over a prefix of the chain.
  assign gt = slot_valid && (data > ctrl.token);

  always_comb begin
    data_next = data;
    if (ctrl.ins_en) begin
      if (!gt) begin
        data_next = prev_gt ? ctrl.token : prev_data;
      end
    end else if (ctrl.rem_en) begin
      data_next = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
